/* rtl/elias_gamma_word_decoder_core_defines.svh */
// ----------------------------------------------------------------------------
// Elias gamma word decoder assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ELIAS_GAMMA_WORD_DECODER_CORE_DEFINES_SVH
`define ELIAS_GAMMA_WORD_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define EGWD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("egwd assertion failed");
// next-cycle implication
`define EGWD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("egwd assertion failed");
`else
`define EGWD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define EGWD_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/egwd_pkg.sv */
// ----------------------------------------------------------------------------
// Elias gamma word decoder package
// Widths and structs shared by the word shifter, bit decoder and output queue.
// ----------------------------------------------------------------------------
package egwd_pkg;

	localparam int WORD_BITS    = 32;
	localparam int CNT_W        = $clog2(WORD_BITS);
	localparam int VALUE_W      = 32;
	localparam int PREFIX_LIMIT = 32;
	localparam int ZC_W         = $clog2(PREFIX_LIMIT);

	// one stream bit as presented to the decoder
	typedef struct packed {
		logic bit_val;
		logic word_end;
		logic eos;
	} stream_bit_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               err;
	} result_t;

endpackage

/* rtl/elias_gamma_word_decoder_core.sv */
// Throughput: one stream bit per cycle through the bit decoder while the queue has room;
// the next word is taken on the cycle that consumes the last bit of the current one.
// Output: a result leaves the queue when the next result or the word end is seen,
// so the last result of a word goes through the pending and then the output register.
// Reset: arst_n clears decoder counters, queue and handshake state at once.
// ----------------------------------------------------------------------------
// Elias gamma word decoder core
// Decodes a gamma bitstream carried in 32-bit words, one bit per cycle unless the queue is full.
// ----------------------------------------------------------------------------
module elias_gamma_word_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] code_word,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] decoded_value,
	output logic        prefix_error,
	output logic        last_of_word
);

	egwd_pkg::stream_bit_t sbit;
	egwd_pkg::result_t     res;
	logic                  bit_valid;
	logic                  can_step;
	logic                  step;
	logic                  res_valid;

	// advance one bit when a bit is held and the queue has room
	assign step = bit_valid && can_step;

	egwd_wordshift u_shift (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.code_word     (code_word),
		.end_of_stream (end_of_stream),
		.step          (step),
		.bit_valid     (bit_valid),
		.sbit          (sbit)
	);

	egwd_bitdec u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.sbit      (sbit),
		.res_valid (res_valid),
		.res       (res)
	);

	egwd_outq u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.word_end      (sbit.word_end),
		.res_valid     (res_valid),
		.res           (res),
		.can_step      (can_step),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.decoded_value (decoded_value),
		.prefix_error  (prefix_error),
		.last_of_word  (last_of_word)
	);

endmodule

/* rtl/egwd_wordshift.sv */
// ----------------------------------------------------------------------------
// Word shift register
// Takes one code word and hands it out one bit per cycle while stepped, MSB first.
// ----------------------------------------------------------------------------
module egwd_wordshift (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            code_word,
	input  logic                   end_of_stream,
	input  logic                   step,
	output logic                   bit_valid,
	output egwd_pkg::stream_bit_t  sbit
);

	localparam int WB = egwd_pkg::WORD_BITS;
	localparam int CW = egwd_pkg::CNT_W;

	logic [WB-1:0] word_q;
	logic          eos_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          last_bit;
	logic          accept;

	assign last_bit  = (cnt_q == CW'(WB - 1));
	// take the next word while the last bit of this one is consumed
	assign in_ready  = !busy_q || (step && last_bit);
	assign accept    = in_valid && in_ready;
	assign bit_valid = busy_q;

	assign sbit.bit_val  = word_q[WB-1];
	assign sbit.word_end = last_bit;
	assign sbit.eos      = eos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (step) begin
			if (last_bit) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= WB'(code_word);
			eos_q  <= end_of_stream;
		end else if (step) begin
			word_q <= {word_q[WB-2:0], 1'b0};
		end
	end

endmodule

/* rtl/egwd_bitdec.sv */
// ----------------------------------------------------------------------------
// Gamma bit decoder
// Counts prefix zeros and shifts in value bits, one stream bit per step.
// ----------------------------------------------------------------------------
module egwd_bitdec (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  egwd_pkg::stream_bit_t sbit,
	output logic                  res_valid,
	output egwd_pkg::result_t     res
);

	localparam int VW = egwd_pkg::VALUE_W;
	localparam int ZW = egwd_pkg::ZC_W;

	logic [ZW-1:0] zc_q, zc_d;
	logic          coll_q, coll_d;
	logic [ZW-1:0] rem_q, rem_d;
	logic [VW-1:0] acc_q, acc_d;
	logic [VW-1:0] acc_shift;

	assign acc_shift = {acc_q[VW-2:0], sbit.bit_val};

	always_comb begin
		zc_d      = zc_q;
		coll_d    = coll_q;
		rem_d     = rem_q;
		acc_d     = acc_q;
		res_valid = 1'b0;
		res.value = '0;
		res.err   = 1'b0;
		if (coll_q) begin
			acc_d = acc_shift;
			rem_d = rem_q - 1'b1;
			if (rem_q == ZW'(1)) begin
				res_valid = 1'b1;
				res.value = acc_shift;
				coll_d    = 1'b0;
				zc_d      = '0;
			end
		end else if (!sbit.bit_val) begin
			// prefix too long: flag it and start over
			if (zc_q == ZW'(egwd_pkg::PREFIX_LIMIT - 1)) begin
				res_valid = 1'b1;
				res.err   = 1'b1;
				zc_d      = '0;
			end else begin
				zc_d = zc_q + 1'b1;
			end
		end else if (zc_q == '0) begin
			res_valid = 1'b1;
			res.value = VW'(1);
		end else begin
			coll_d = 1'b1;
			rem_d  = zc_q;
			acc_d  = VW'(1);
		end
		// drop any unfinished code after the final word
		if (sbit.word_end && sbit.eos) begin
			zc_d   = '0;
			coll_d = 1'b0;
			rem_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zc_q   <= '0;
			coll_q <= 1'b0;
			rem_q  <= '0;
		end else if (step) begin
			zc_q   <= zc_d;
			coll_q <= coll_d;
			rem_q  <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			acc_q <= acc_d;
		end
	end

endmodule

/* rtl/egwd_outq.sv */
// ----------------------------------------------------------------------------
// Result queue
// Holds the newest result until it is known whether it ends its word, then
// moves it to the output register.
// ----------------------------------------------------------------------------
`include "elias_gamma_word_decoder_core_defines.svh"

module egwd_outq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      word_end,
	input  logic                      res_valid,
	input  egwd_pkg::result_t         res,
	output logic                      can_step,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [31:0]               decoded_value,
	output logic                      prefix_error,
	output logic                      last_of_word
);

	logic              pend_valid_q;
	logic              pend_close_q;
	egwd_pkg::result_t pend_q;
	logic              out_valid_q;
	egwd_pkg::result_t out_q;
	logic              out_last_q;
	logic              out_free;
	logic              push;

	assign out_free = !out_valid_q || out_ready;
	// a step may push the pending item, so it needs room when one is held
	assign can_step = out_free || !pend_valid_q;
	assign push     = pend_valid_q && out_free && (pend_close_q || (step && res_valid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_close_q <= 1'b0;
		end else if (step && res_valid) begin
			pend_valid_q <= 1'b1;
			pend_close_q <= word_end;
		end else if (push) begin
			pend_valid_q <= 1'b0;
			pend_close_q <= 1'b0;
		end else if (step && word_end && pend_valid_q) begin
			pend_close_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			pend_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= pend_close_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign decoded_value = out_q.value;
	assign prefix_error  = out_q.err;
	assign last_of_word  = out_last_q;

	`EGWD_ASSERT_IMP(a_close_has_item, clk, arst_n, pend_close_q, pend_valid_q)
	`EGWD_ASSERT_IMP(a_step_has_room, clk, arst_n, step && pend_valid_q, out_free)
	`EGWD_ASSERT_NXT(a_push_shows, clk, arst_n, push, out_valid_q)

endmodule
